// File: rtl/scspg_pkg.sv
// ----------------------------------------------------------------------------
// S-curve stepper package
// Shared constants, codes, types and the sine table of the S-curve stepper.
// ----------------------------------------------------------------------------
package scspg_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
    localparam int TIME_BITS        = 32;
    localparam int COUNT_BITS       = 24;
    localparam int CFG_INDEX_BITS   = 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] C1 = 64'd1686629713;
    localparam logic [63:0] C3 = 64'd693598668;
    localparam logic [63:0] C5 = 64'd85569306;
    localparam logic [63:0] C7 = 64'd5026995;
    localparam logic [63:0] C9 = 64'd172272;

    localparam logic [15:0] K_INV_4PI     = 16'd5215;
    localparam logic [15:0] K_INV_4PI2_X2 = 16'd3320;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSES_PER_REV = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSE_WIDTH_US = 1'd1;

    localparam logic OP_CONTROL = 1'b0;
    localparam logic OP_MOVE    = 1'b1;

    typedef enum logic [1:0] {
        MOTOR_UNKNOWN = 2'd0,
        MOTOR_IDLE    = 2'd1,
        MOTOR_MOVING  = 2'd2,
        MOTOR_FAILED  = 2'd3
    } t_motor;

    typedef logic signed [15:0] t_sine_rom [SINE_TABLE_DEPTH];

    function automatic logic [63:0] f_quarter_sine(input logic [63:0] z);
        logic [63:0] z2;
        logic [63:0] a;
        z2 = (z * z) >> 30;
        a  = C9;
        a  = C7 - ((a * z2) >> 30);
        a  = C5 - ((a * z2) >> 30);
        a  = C3 - ((a * z2) >> 30);
        a  = C1 - ((a * z2) >> 30);
        return (a * z) >> 30;
    endfunction

    function automatic t_sine_rom f_build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] z;
        logic [63:0] v;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            m = 64'(4 * k);
            q = (m / SINE_TABLE_DEPTH) & 64'd3;
            z = ((m % SINE_TABLE_DEPTH) << 30) / SINE_TABLE_DEPTH;
            v = f_quarter_sine(q[0] ? (Q30_ONE - z) : z);
            v = (v + (64'd1 << 14)) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            rom[k] = q[1] ? -$signed(v[15:0]) : $signed(v[15:0]);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_sine_rom();

endpackage

// File: rtl/s_curve_stepper_pulse_generator.sv
// ----------------------------------------------------------------------------
// S-curve stepper pulse generator
// Sinusoidal-jerk S-curve profile with step pulse timing and failure tracking.
// ----------------------------------------------------------------------------
// A move item, or a control item while unknown or idle, goes straight to the
// result register. Other control items run a radix-2 phase divider unless the
// move time is over, then 6 to 11 products on one shared 33x33 multiplier (each
// a multiply and an accumulate state), a decision state and the result register.
// One item is in flight at a time; the next is taken the cycle after the
// result is registered. Synchronous active-low reset: state unknown, counts zero.
module s_curve_stepper_pulse_generator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_operation,
    input  logic [scspg_pkg::TIME_BITS-1:0]       i_now_us,
    input  logic [31:0]                           i_rev_count,
    input  logic [scspg_pkg::TIME_BITS-1:0]       i_duration_us,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_pulse_level,
    output logic [1:0]                            o_motor_state,
    output logic [scspg_pkg::COUNT_BITS-1:0]      o_pulses_done,
    output logic [scspg_pkg::COUNT_BITS-1:0]      o_pulses_expected,
    output logic [scspg_pkg::TIME_BITS-1:0]       o_min_period_us,
    output logic [15:0]                           o_failed_moves,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [scspg_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [15:0]                           i_cfg_data
);
    import scspg_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_MUL  = 6'b000100,
        S_ACC  = 6'b001000,
        S_FIN  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    localparam logic [3:0] M_SQ     = 4'd0;
    localparam logic [3:0] M_TERM   = 4'd1;
    localparam logic [3:0] M_ST     = 4'd2;
    localparam logic [3:0] M_RP     = 4'd3;
    localparam logic [3:0] M_DUE_LO = 4'd4;
    localparam logic [3:0] M_DUE_HI = 4'd5;
    localparam logic [3:0] M_Q_LO   = 4'd6;
    localparam logic [3:0] M_Q_HI   = 4'd7;
    localparam logic [3:0] M_N0     = 4'd8;
    localparam logic [3:0] M_N1     = 4'd9;
    localparam logic [3:0] M_N2     = 4'd10;

    t_state                  r_state;
    t_motor                  r_motor;
    logic [15:0]             r_ppr;
    logic [15:0]             r_pw;
    logic [TIME_BITS-1:0]    r_move_start;
    logic [TIME_BITS-1:0]    r_dur;
    logic [31:0]             r_revs;
    logic [TIME_BITS-1:0]    r_period_start;
    logic [TIME_BITS-1:0]    r_rise;
    logic                    r_pin;
    logic [COUNT_BITS-1:0]   r_issued;
    logic [COUNT_BITS-1:0]   r_due;
    logic [1:0]              r_ov;
    logic [TIME_BITS-1:0]    r_short;
    logic [15:0]             r_fail;

    logic [TIME_BITS-1:0]    r_now;
    logic [TIME_BITS-1:0]    r_t;
    logic [TIME_BITS-1:0]    r_rem;
    logic [16:0]             r_x;
    logic [3:0]              r_cnt;
    logic [3:0]              r_op;
    logic signed [65:0]      r_prod;
    logic [30:0]             r_sq;
    logic [27:0]             r_term;
    logic signed [28:0]      r_st;
    logic [47:0]             r_rp;
    logic [24:0]             r_g24;
    logic [30:0]             r_h;
    logic [111:0]            r_acc;
    logic [111:0]            r_sum;
    logic                    r_slow;

    logic                    r_out_valid;
    logic                    r_out_pin;
    logic [1:0]              r_out_motor;
    logic [COUNT_BITS-1:0]   r_out_done;
    logic [COUNT_BITS-1:0]   r_out_exp;
    logic [TIME_BITS-1:0]    r_out_min;
    logic [15:0]             r_out_fail;

    logic [TIME_BITS-1:0]    w_t;
    logic                    w_fall;
    logic [TIME_BITS-1:0]    w_half_up;
    logic                    w_exceeded;
    logic                    w_first;
    logic [16:0]             w_p;
    logic [SINE_ADDR_BITS-1:0] w_k;
    logic [SINE_ADDR_BITS-1:0] w_kc;
    logic signed [15:0]      w_sin;
    logic signed [15:0]      w_cos;
    logic signed [35:0]      w_g;
    logic signed [35:0]      w_hs;
    logic [24:0]             w_g24;
    logic [30:0]             w_h;
    logic [32:0]             w_rem2;
    logic                    w_ge;
    logic signed [32:0]      w_ma;
    logic signed [32:0]      w_mb;
    logic signed [65:0]      w_mprod;
    logic [111:0]            w_due_sum;
    logic [71:0]             w_due;
    logic [TIME_BITS-1:0]    w_n;
    logic                    w_ready;
    logic [1:0]              w_ov_inc;
    logic [COUNT_BITS-1:0]   w_issued_inc;

    assign w_t    = i_now_us - r_move_start;
    assign w_fall = r_pin && ((i_now_us - r_rise) >= TIME_BITS'(r_pw));

    assign w_half_up  = (r_dur >> 1) + TIME_BITS'(r_dur[0]);
    assign w_exceeded = r_t > r_dur;
    assign w_first    = r_t < w_half_up;
    assign w_p        = w_first ? r_x : (r_x - 17'd32768);
    assign w_k        = w_p[14 -: SINE_ADDR_BITS];
    assign w_kc       = w_k + SINE_ADDR_BITS'(SINE_TABLE_DEPTH / 4);
    assign w_sin      = SINE_ROM[w_k];
    assign w_cos      = SINE_ROM[w_kc];

    always_comb begin
        if (w_first) begin
            w_g  = $signed(36'({r_sq, 1'b0})) - $signed(36'(r_term));
            w_hs = $signed(36'({w_p, 15'd0})) - 36'(r_st);
        end else begin
            w_g  = $signed(36'(r_term)) - $signed(36'({r_sq, 1'b0}))
                 + $signed(36'({w_p, 17'd0})) + $signed(36'(64'd1 << 31));
            w_hs = 36'(r_st) - $signed(36'({w_p, 15'd0}))
                 + $signed(36'(64'd1 << 30));
        end
        if (w_g < 0) begin
            w_g24 = '0;
        end else if (w_g > $signed(36'(64'd1 << 32))) begin
            w_g24 = 25'd1 << 24;
        end else begin
            w_g24 = w_g[32:8];
        end
        if (w_hs < 0) begin
            w_h = '0;
        end else begin
            w_h = w_hs[30:0];
        end
    end

    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_dur};

    always_comb begin
        case (r_op)
            M_SQ: begin
                w_ma = $signed(33'(w_p));
                w_mb = $signed(33'(w_p));
            end
            M_TERM: begin
                w_ma = 33'sd32768 - 33'(w_cos);
                w_mb = $signed(33'(K_INV_4PI2_X2));
            end
            M_ST: begin
                w_ma = 33'(w_sin);
                w_mb = $signed(33'(K_INV_4PI));
            end
            M_RP: begin
                w_ma = $signed(33'(r_revs));
                w_mb = $signed(33'(r_ppr));
            end
            M_DUE_LO: begin
                w_ma = $signed(33'(r_rp[23:0]));
                w_mb = $signed(33'(r_g24));
            end
            M_DUE_HI: begin
                w_ma = $signed(33'(r_rp[47:24]));
                w_mb = $signed(33'(r_g24));
            end
            M_Q_LO: begin
                w_ma = $signed(33'(r_h));
                w_mb = $signed(33'(r_rp[31:0]));
            end
            M_Q_HI: begin
                w_ma = $signed(33'(r_h));
                w_mb = $signed(33'(r_rp[47:32]));
            end
            M_N0: begin
                w_ma = $signed(33'(w_n));
                w_mb = $signed(33'(r_acc[31:0]));
            end
            M_N1: begin
                w_ma = $signed(33'(w_n));
                w_mb = $signed(33'(r_acc[63:32]));
            end
            M_N2: begin
                w_ma = $signed(33'(w_n));
                w_mb = $signed(33'(r_acc[78:64]));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mprod   = w_ma * w_mb;
    assign w_due_sum = r_acc + (112'(r_prod[63:0]) << 24);
    assign w_due     = w_due_sum[111:40];

    assign w_n          = r_now - r_period_start;
    assign w_ready      = !r_pin && (r_issued < r_due)
                        && (r_slow ? (r_sum >= 112'({r_dur, 44'd0}))
                                   : (w_n >= w_half_up));
    assign w_ov_inc     = (w_exceeded && (r_ov != 2'd3)) ? (r_ov + 2'd1) : r_ov;
    assign w_issued_inc = (r_issued != COUNT_MAX) ? (r_issued + 1'b1) : r_issued;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_motor        <= MOTOR_UNKNOWN;
            r_ppr          <= 16'd200;
            r_pw           <= 16'd5;
            r_move_start   <= '0;
            r_dur          <= '0;
            r_revs         <= '0;
            r_period_start <= '0;
            r_rise         <= '0;
            r_pin          <= 1'b0;
            r_issued       <= '0;
            r_due          <= '0;
            r_ov           <= '0;
            r_short        <= '0;
            r_fail         <= '0;
            r_op           <= M_SQ;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PULSES_PER_REV: r_ppr <= i_cfg_data;
                    CFG_PULSE_WIDTH_US: r_pw <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_now <= i_now_us;
                        if (w_fall) begin
                            r_pin <= 1'b0;
                        end
                        if (i_operation == OP_MOVE) begin
                            if (r_motor == MOTOR_IDLE || r_motor == MOTOR_UNKNOWN) begin
                                r_revs         <= i_rev_count;
                                r_dur          <= i_duration_us;
                                r_period_start <= i_now_us;
                                r_move_start   <= i_now_us;
                                if (r_motor == MOTOR_UNKNOWN) begin
                                    r_short <= i_duration_us;
                                end
                                r_motor  <= MOTOR_MOVING;
                                r_due    <= '0;
                                r_issued <= '0;
                                r_ov     <= '0;
                            end
                            r_state <= S_DONE;
                        end else if (r_motor == MOTOR_MOVING || r_motor == MOTOR_FAILED) begin
                            r_t  <= w_t;
                            r_op <= M_SQ;
                            if (r_dur == '0 || w_t >= r_dur) begin
                                r_x     <= 17'h10000;
                                r_state <= S_MUL;
                            end else begin
                                r_rem   <= w_t;
                                r_x     <= '0;
                                r_cnt   <= '0;
                                r_state <= S_DIV;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? TIME_BITS'(w_rem2 - {1'b0, r_dur}) : w_rem2[31:0];
                    r_x   <= {r_x[15:0], w_ge};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_mprod;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_op <= r_op + 4'd1;
                    case (r_op)
                        M_SQ: begin
                            r_sq    <= r_prod[30:0];
                            r_state <= S_MUL;
                        end
                        M_TERM: begin
                            r_term  <= r_prod[27:0];
                            r_state <= S_MUL;
                        end
                        M_ST: begin
                            r_st    <= r_prod[28:0];
                            r_state <= S_MUL;
                        end
                        M_RP: begin
                            r_rp    <= r_prod[47:0];
                            r_g24   <= w_g24;
                            r_h     <= w_h;
                            r_state <= S_MUL;
                        end
                        M_DUE_LO: begin
                            r_acc   <= 112'(r_prod[63:0]) + (112'd1 << 39);
                            r_state <= S_MUL;
                        end
                        M_DUE_HI: begin
                            r_due  <= (w_due > 72'(COUNT_MAX)) ? COUNT_MAX
                                                               : w_due[COUNT_BITS-1:0];
                            r_slow <= (r_rp != '0) && (r_h != '0);
                            if ((r_rp == '0) || (r_h == '0)) begin
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end
                        M_Q_LO: begin
                            r_acc   <= 112'(r_prod[63:0]);
                            r_state <= S_MUL;
                        end
                        M_Q_HI: begin
                            r_acc   <= r_acc + (112'(r_prod[63:0]) << 32);
                            r_state <= S_MUL;
                        end
                        M_N0: begin
                            r_sum   <= 112'(r_prod[63:0]);
                            r_state <= S_MUL;
                        end
                        M_N1: begin
                            r_sum   <= r_sum + (112'(r_prod[63:0]) << 32);
                            r_state <= S_MUL;
                        end
                        M_N2: begin
                            r_sum   <= r_sum + (112'(r_prod[63:0]) << 64);
                            r_state <= S_FIN;
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_FIN: begin
                    r_state <= S_DONE;
                    if (w_ready) begin
                        r_ov <= w_ov_inc;
                        if (w_ov_inc > 2'd1) begin
                            r_motor <= MOTOR_FAILED;
                            r_fail  <= r_fail + 16'd1;
                        end else begin
                            if (w_n < r_short) begin
                                r_short <= w_n;
                            end
                            r_period_start <= r_now;
                            r_rise         <= r_now;
                            r_pin          <= 1'b1;
                            r_issued       <= w_issued_inc;
                            if (w_issued_inc >= r_due && w_exceeded) begin
                                r_motor <= MOTOR_IDLE;
                            end
                        end
                    end else if (r_issued >= r_due && w_exceeded) begin
                        r_motor <= MOTOR_IDLE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_pin   <= r_pin;
                        r_out_motor <= r_motor;
                        r_out_done  <= r_issued;
                        r_out_exp   <= r_due;
                        r_out_min   <= r_short;
                        r_out_fail  <= r_fail;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_pulse_level     = r_out_pin;
    assign o_motor_state     = r_out_motor;
    assign o_pulses_done     = r_out_done;
    assign o_pulses_expected = r_out_exp;
    assign o_min_period_us   = r_out_min;
    assign o_failed_moves    = r_out_fail;

endmodule

// File: rtl/scspg_checker.sv
// ----------------------------------------------------------------------------
// S-curve stepper port checker
// Watches the top-level ports of the S-curve stepper over time.
// ----------------------------------------------------------------------------
module scspg_port_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic                                  o_pulse_level,
    input logic [1:0]                            o_motor_state,
    input logic [scspg_pkg::COUNT_BITS-1:0]      o_pulses_done
);
    import scspg_pkg::*;

    // Reset leaves no result pending and the input side open.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset did not clear the result and input stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_pulses_done) && $stable(o_motor_state)))
        else $error("stalled result changed");

    // Accepting an item raises the input stall, so no two items are accepted back to back.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted on back-to-back cycles");

    // Before the first move no pulse may ever be issued.
    a_unknown_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_motor_state == MOTOR_UNKNOWN) |->
            (!o_pulse_level && o_pulses_done == '0))
        else $error("pulse activity before the first move");

endmodule

bind s_curve_stepper_pulse_generator scspg_port_checker u_scspg_port_checker (.*);

// File: verif/scspg_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// S-curve stepper result checker
// Watches the item, result and register channels of the pulse generator,
// predicts the result of every accepted item from its own profile model and
// compares each delivered result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module scspg_checker
    import scspg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_operation,
    input  logic [TIME_BITS-1:0]      i_now_us,
    input  logic [31:0]               i_rev_count,
    input  logic [TIME_BITS-1:0]      i_duration_us,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_pulse_level,
    input  logic [1:0]                i_motor_state,
    input  logic [COUNT_BITS-1:0]     i_pulses_done,
    input  logic [COUNT_BITS-1:0]     i_pulses_expected,
    input  logic [TIME_BITS-1:0]      i_min_period_us,
    input  logic [15:0]               i_failed_moves,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [15:0]               i_cfg_data,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_high_results
);

    typedef struct packed {
        logic                  pin;
        t_motor                state;
        logic [COUNT_BITS-1:0] done;
        logic [COUNT_BITS-1:0] due;
        logic [TIME_BITS-1:0]  min_gap;
        logic [15:0]           fails;
    } t_status;

    localparam logic [63:0] TMASK = 64'hFFFF_FFFF;
    localparam logic [63:0] CMAX  = 64'(COUNT_MAX);

    t_status status_q[$];

    logic [63:0] steps_per_rev, width_us;
    t_motor      mode;
    logic [63:0] start_us, span_us, period_from_us, rise_us, pin;
    logic [63:0] issued, called, overruns, min_gap, fail_cnt, revs;

    function automatic logic [63:0] quarter_wave(input logic [63:0] z);
        logic [63:0] coef [5];
        logic [63:0] z2;
        logic [63:0] acc;
        coef = '{C9, C7, C5, C3, C1};
        z2  = (z * z) >> 30;
        acc = coef[0];
        for (int i = 1; i < 5; i++) begin
            acc = coef[i] - ((acc * z2) >> 30);
        end
        return (acc * z) >> 30;
    endfunction

    function automatic longint wave_at(input logic [63:0] k, input bit cosine);
        logic [63:0] m;
        logic [63:0] quad;
        logic [63:0] z;
        logic [63:0] v;
        m    = 4 * k + (cosine ? 64'(SINE_TABLE_DEPTH) : 64'd0);
        quad = (m / SINE_TABLE_DEPTH) & 64'd3;
        z    = ((m % SINE_TABLE_DEPTH) << 30) / SINE_TABLE_DEPTH;
        v    = quarter_wave(quad[0] ? (Q30_ONE - z) : z);
        v    = (v + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return quad[1] ? -longint'(v) : longint'(v);
    endfunction

    function automatic logic [63:0] phase_q16(input logic [63:0] t, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] q;
        if (d == 0 || t >= d) begin
            return 64'd65536;
        end
        rem = t;
        q   = 0;
        for (int i = 0; i < 16; i++) begin
            q = q << 1;
            if (rem >= d - rem) begin
                rem = rem - (d - rem);
                q   = q | 64'd1;
            end else begin
                rem = rem + rem;
            end
        end
        return q;
    endfunction

    task automatic advance_profile(input logic [63:0] now);
        logic [63:0]  t, d, half_up, x, p, k, rp, g24, a_hi, carry, dv, n, hu;
        logic [191:0] prod;
        longint       s, c, term, sk, g, h;
        bit           exceeded, first_half, ready;
        t          = (now - start_us) & TMASK;
        d          = span_us;
        half_up    = (d >> 1) + (d & 64'd1);
        exceeded   = t > d;
        first_half = t < half_up;
        x          = phase_q16(t, d);
        p          = first_half ? x : x - 64'd32768;
        k          = (((p << 1) & 64'hFFFF) * SINE_TABLE_DEPTH) >> 16;
        s          = wave_at(k, 1'b0);
        c          = wave_at(k, 1'b1);
        term       = (32768 - c) * longint'(K_INV_4PI2_X2);
        sk         = s * longint'(K_INV_4PI);
        if (first_half) begin
            g = 2 * longint'(x * x) - term;
            h = longint'(x << 15) - sk;
        end else begin
            g = term - 2 * longint'(p * p) + longint'(p << 17) + (longint'(1) << 31);
            h = sk - longint'(p << 15) + (longint'(1) << 30);
        end
        if (g < 0) g = 0;
        if (g > (longint'(1) << 32)) g = longint'(1) << 32;
        if (h < 0) h = 0;

        rp     = revs * steps_per_rev;
        g24    = 64'(g) >> 8;
        a_hi   = (rp >> 24) * g24;
        carry  = ((rp & 64'hFF_FFFF) * g24 + (64'd1 << 39)) >> 24;
        dv     = (a_hi + carry) >> 16;
        called = dv > CMAX ? CMAX : dv;

        if (pin == 0 && issued < called) begin
            n = (now - period_from_us) & TMASK;
            if (rp == 0 || h == 0) begin
                ready = n >= half_up;
            end else begin
                hu    = 64'(h);
                prod  = 192'(n) * 192'(rp) * 192'(hu);
                ready = prod >= (192'(d) << 44);
            end
            if (ready) begin
                if (exceeded && overruns < 3) overruns = overruns + 1;
                if (overruns > 1) begin
                    mode     = MOTOR_FAILED;
                    fail_cnt = (fail_cnt + 1) & 64'hFFFF;
                    return;
                end
                if (n < min_gap) min_gap = n;
                period_from_us = now;
                rise_us        = now;
                pin            = 1;
                if (issued < CMAX) issued = issued + 1;
            end
        end
        if (issued >= called && exceeded) mode = MOTOR_IDLE;
    endtask

    task automatic predict_item();
        logic [63:0] now;
        t_status     r;
        now = 64'(i_now_us);
        if (pin != 0 && ((now - rise_us) & TMASK) >= width_us) pin = 0;
        if (i_operation == OP_MOVE) begin
            if (mode == MOTOR_IDLE || mode == MOTOR_UNKNOWN) begin
                revs           = 64'(i_rev_count);
                span_us        = 64'(i_duration_us);
                period_from_us = now;
                if (mode == MOTOR_UNKNOWN) min_gap = span_us;
                mode     = MOTOR_MOVING;
                start_us = now;
                called   = 0;
                issued   = 0;
                overruns = 0;
            end
        end else if (mode == MOTOR_MOVING || mode == MOTOR_FAILED) begin
            advance_profile(now);
        end
        r.pin     = pin[0];
        r.state   = mode;
        r.done    = issued[COUNT_BITS-1:0];
        r.due     = called[COUNT_BITS-1:0];
        r.min_gap = min_gap[TIME_BITS-1:0];
        r.fails   = fail_cnt[15:0];
        status_q.push_back(r);
    endtask

    task automatic compare_result();
        t_status e;
        if (status_q.size() == 0) begin
            $display("%0t: result arrived with no item outstanding", $time);
            o_errors++;
            return;
        end
        e = status_q.pop_front();
        o_checked++;
        if (i_pulse_level) o_high_results++;
        if (i_pulse_level !== e.pin) begin
            $display("%0t: pulse_level expected %0d actual %0d", $time, e.pin, i_pulse_level);
            o_errors++;
        end
        if (i_motor_state !== e.state) begin
            $display("%0t: motor_state expected %0d actual %0d", $time, e.state,
                     i_motor_state);
            o_errors++;
        end
        if (i_pulses_done !== e.done) begin
            $display("%0t: pulses_done expected %0d actual %0d", $time, e.done,
                     i_pulses_done);
            o_errors++;
        end
        if (i_pulses_expected !== e.due) begin
            $display("%0t: pulses_expected expected %0d actual %0d", $time, e.due,
                     i_pulses_expected);
            o_errors++;
        end
        if (i_min_period_us !== e.min_gap) begin
            $display("%0t: min_period_us expected %0d actual %0d", $time, e.min_gap,
                     i_min_period_us);
            o_errors++;
        end
        if (i_failed_moves !== e.fails) begin
            $display("%0t: failed_moves expected %0d actual %0d", $time, e.fails,
                     i_failed_moves);
            o_errors++;
        end
    endtask

    initial begin
        o_errors       = 0;
        o_checked      = 0;
        o_high_results = 0;
    end

    assign o_pending = status_q.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            status_q.delete();
            steps_per_rev  = 64'd200;
            width_us       = 64'd5;
            mode           = MOTOR_UNKNOWN;
            start_us       = 0;
            span_us        = 0;
            period_from_us = 0;
            rise_us        = 0;
            pin            = 0;
            issued         = 0;
            called         = 0;
            overruns       = 0;
            min_gap        = 0;
            fail_cnt       = 0;
            revs           = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_PULSES_PER_REV) begin
                    steps_per_rev = 64'(i_cfg_data);
                end else if (i_cfg_index == CFG_PULSE_WIDTH_US) begin
                    width_us = 64'(i_cfg_data);
                end
            end
            if (i_out_valid && !i_out_stall) compare_result();
            if (i_in_valid && !i_in_stall) predict_item();
        end
    end

endmodule

// File: verif/tb_s_curve_stepper_pulse_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// S-curve stepper pulse generator testbench
// Drives move and control items through several register settings, with
// bursty input and a patterned output stall, and takes the verdict from the
// checker that predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_s_curve_stepper_pulse_generator;
    import scspg_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      operation;
    logic [TIME_BITS-1:0]      now_us;
    logic [31:0]               rev_count;
    logic [TIME_BITS-1:0]      duration_us;
    logic                      out_valid;
    logic                      out_stall;
    logic                      pulse_level;
    logic [1:0]                motor_state;
    logic [COUNT_BITS-1:0]     pulses_done;
    logic [COUNT_BITS-1:0]     pulses_expected;
    logic [TIME_BITS-1:0]      min_period_us;
    logic [15:0]               failed_moves;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [15:0]               cfg_data;
    int                        errors;
    int                        pending;
    int                        checked;
    int                        high_results;

    logic [31:0] clock_us;
    logic [15:0] steps_per_rev;
    int          items_sent;
    int          moves_sent;
    int          cfg_writes;
    int          burst_left;
    int          stall_mode;
    int          stall_tick;

    s_curve_stepper_pulse_generator dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_operation       (operation),
        .i_now_us          (now_us),
        .i_rev_count       (rev_count),
        .i_duration_us     (duration_us),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_pulse_level     (pulse_level),
        .o_motor_state     (motor_state),
        .o_pulses_done     (pulses_done),
        .o_pulses_expected (pulses_expected),
        .o_min_period_us   (min_period_us),
        .o_failed_moves    (failed_moves),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    scspg_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_operation       (operation),
        .i_now_us          (now_us),
        .i_rev_count       (rev_count),
        .i_duration_us     (duration_us),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_pulse_level     (pulse_level),
        .i_motor_state     (motor_state),
        .i_pulses_done     (pulses_done),
        .i_pulses_expected (pulses_expected),
        .i_min_period_us   (min_period_us),
        .i_failed_moves    (failed_moves),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_errors          (errors),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_high_results    (high_results)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // The receiver switches between free flow, light, heavy and periodic stall.
    initial begin
        out_stall  = 1'b0;
        stall_mode = 0;
        stall_tick = 0;
        forever begin
            @(negedge clk);
            stall_tick++;
            if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= (stall_tick % 3 == 0);
            endcase
        end
    end

    task automatic send_item(input logic op, input logic [31:0] now,
                             input logic [31:0] revs, input logic [31:0] span);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        operation   <= op;
        now_us      <= now;
        rev_count   <= revs;
        duration_us <= span;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (op == OP_MOVE) moves_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx == CFG_PULSES_PER_REV) steps_per_rev = val;
    endtask

    // A move, then control ticks with a stray move now and then; the ticks keep
    // pace with the profile and run on past its end so the motor can settle to idle.
    task automatic run_move(input int span_lo, input int span_hi, input int step_max);
        int          span;
        int          target;
        longint      revs;
        logic [31:0] start;
        span   = $urandom_range(span_lo, span_hi);
        target = $urandom_range(1, span / (4 * step_max) + 1);
        revs   = ((longint'(target) << 16) + $urandom_range(0, 65535)) / steps_per_rev;
        start  = clock_us;
        send_item(OP_MOVE, clock_us, 32'(revs), 32'(span));
        while (clock_us - start <= 32'(span + 3 * step_max + 8)) begin
            if ($urandom_range(0, 40) == 0) begin
                send_item(OP_MOVE, $urandom, $urandom, $urandom);
            end
            if ($urandom_range(0, 30) != 0) clock_us += $urandom_range(1, step_max);
            send_item(OP_CONTROL, clock_us, $urandom, $urandom);
        end
    endtask

    initial begin
        logic [15:0] setting_p [5];
        logic [15:0] setting_w [5];
        int          ph;
        setting_p  = '{16'd1, 16'd65535, 16'd37, 16'd200, 16'd4097};
        setting_w  = '{16'd1, 16'd2, 16'd1, 16'd3, 16'd1};
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_CONTROL;
        now_us     = '0;
        rev_count  = '0;
        duration_us = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_PULSES_PER_REV;
        cfg_data   = '0;
        clock_us   = 32'd1000;
        steps_per_rev = 16'd200;
        items_sent = 0;
        moves_sent = 0;
        cfg_writes = 0;
        burst_left = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: control before any move, a zero-revolution move, the
        // shortest duration, a move while busy and control while idle.
        send_item(OP_CONTROL, $urandom, $urandom, $urandom);
        send_item(OP_MOVE, clock_us, 32'd3277, 32'd200);
        send_item(OP_MOVE, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (12) begin
            clock_us += 20;
            send_item(OP_CONTROL, clock_us, 32'd0, 32'd1);
        end
        send_item(OP_MOVE, clock_us, 32'd0, 32'd1);
        clock_us += 3;
        send_item(OP_CONTROL, clock_us, 32'd0, 32'd0);
        send_item(OP_CONTROL, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_item(OP_CONTROL, 32'd0, 32'd0, 32'd0);
        send_item(OP_MOVE, clock_us, 32'd1311, 32'd1);
        clock_us += 2;
        send_item(OP_CONTROL, clock_us, 32'd0, 32'd0);
        drain();

        // A move that runs across the wrap of the time base.
        clock_us = 32'hFFFF_FF80;
        run_move(200, 300, 3);
        drain();

        ph = 0;
        while (items_sent < 1650) begin
            write_reg(CFG_PULSES_PER_REV, setting_p[ph % 5]);
            write_reg(CFG_PULSE_WIDTH_US, setting_w[ph % 5]);
            repeat (3) begin
                run_move(60, 400, 4);
                repeat ($urandom_range(0, 3)) begin
                    send_item(OP_CONTROL, $urandom, $urandom, $urandom);
                end
            end
            drain();
            ph++;
        end

        // Failure path: a wide pulse and a move that cannot keep up.
        write_reg(CFG_PULSES_PER_REV, 16'd200);
        write_reg(CFG_PULSE_WIDTH_US, 16'd65535);
        send_item(OP_MOVE, clock_us, 32'hFFFF_FFFF, 32'd50);
        repeat (20) begin
            clock_us += $urandom_range(1, 5);
            send_item(OP_CONTROL, clock_us, 32'd0, 32'd0);
        end
        repeat (6) begin
            clock_us += 32'd70000;
            send_item(OP_CONTROL, clock_us, 32'd0, 32'd0);
        end
        send_item(OP_MOVE, clock_us, 32'h8000_0000, 32'hFFFF_FFFF);
        drain();

        $display("Ran %0d items (%0d moves) over %0d register writes.",
                 items_sent, moves_sent, cfg_writes);
        $display("Checked %0d results, %0d with the step pin high.", checked, high_results);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
